// ===== src/hss_pkg.sv =====
package hss_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned COIL_W  = 4;
    localparam int unsigned CFG_ADDR_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET    = 16'd50;
    localparam logic [COUNT_W-1:0] STEP_PERIOD_RESET = 16'd100;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_TICKS    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_PERIOD_TICKS = 1'd1;

    localparam logic [COIL_W-1:0] COILS_OFF = 4'b0000;

    // eight-phase half-step coil pattern, bit0 = coil one
    function automatic logic [COIL_W-1:0] hss_phase_coils(input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] coils;
        case (idx)
            3'd0:    coils = 4'b1000;
            3'd1:    coils = 4'b1100;
            3'd2:    coils = 4'b0100;
            3'd3:    coils = 4'b0110;
            3'd4:    coils = 4'b0010;
            3'd5:    coils = 4'b0011;
            3'd6:    coils = 4'b0001;
            3'd7:    coils = 4'b1001;
            default: coils = COILS_OFF;
        endcase
        return coils;
    endfunction

endpackage

// ===== src/hss_debounce.sv =====
module hss_debounce
    import hss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_level,
    input  logic [COUNT_W-1:0] i_debounce_ticks,
    output logic               o_fire
);

    logic               r_prev;
    logic [COUNT_W-1:0] r_count;
    logic               r_taken;

    logic               n_prev;
    logic [COUNT_W-1:0] n_count;
    logic               n_taken;
    logic               taken_base;
    logic               fire;

    always_comb begin
        if (i_level != r_prev) begin
            n_count    = '0;
            taken_base = 1'b0;
        end else begin
            n_count    = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
            taken_base = r_taken;
        end
        // one toggle per press: fire once the count passes the threshold
        fire    = i_level && (n_count > i_debounce_ticks) && !taken_base;
        n_taken = taken_base | fire;
        n_prev  = i_level;
    end

    assign o_fire = i_en & fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_count <= '0;
            r_taken <= 1'b0;
        end else if (i_en) begin
            r_prev  <= n_prev;
            r_count <= n_count;
            r_taken <= n_taken;
        end
    end

endmodule

// ===== src/button_driven_half_step_stepper.sv =====
// Two-button half-step stepper sequencer. Each input transaction is one
// millisecond tick carrying both sampled button levels; each produces exactly
// one result transaction holding the coil pattern, both lamp states and a
// stepped flag. A debounced press toggles its button's lamp (lighting one
// clears the other); the left lamp walks the eight-phase table forward, the
// right lamp backward, one phase every step_period_ticks ticks. Throughput is
// one tick per clock: the whole update is a single pass of counter, compare
// and table logic into the result register, so the result appears on the
// cycle after the input is taken, and a new tick is taken whenever the result
// register is empty or being drained in the same cycle. Configuration writes
// (index 0 debounce_ticks, index 1 step_period_ticks) take effect immediately.
module button_driven_half_step_stepper
    import hss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [COUNT_W-1:0]    i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_left_level,
    input  logic                  i_right_level,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COIL_W-1:0]     o_coil_drive,
    output logic                  o_left_lamp_on,
    output logic                  o_right_lamp_on,
    output logic                  o_stepped
);

    logic [COUNT_W-1:0] r_debounce_ticks;
    logic [COUNT_W-1:0] r_step_period;

    logic               r_left_lamp;
    logic               r_right_lamp;
    logic [PHASE_W-1:0] r_phase;
    logic [COUNT_W-1:0] r_since;
    logic [COIL_W-1:0]  r_coils;

    logic               r_out_valid;
    logic [COIL_W-1:0]  r_out_coils;
    logic               r_out_left;
    logic               r_out_right;
    logic               r_out_stepped;

    logic               n_left_lamp;
    logic               n_right_lamp;
    logic [PHASE_W-1:0] n_phase;
    logic [COUNT_W-1:0] n_since;
    logic [COIL_W-1:0]  n_coils;

    logic               in_acc;
    logic               left_fire;
    logic               right_fire;
    logic               left_mid;
    logic               right_mid;
    logic [COUNT_W-1:0] since_inc;
    logic               step_now;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
            r_step_period    <= STEP_PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEBOUNCE_TICKS:    r_debounce_ticks <= i_cfg_data;
                CFG_STEP_PERIOD_TICKS: r_step_period    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hss_debounce u_left_db (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (in_acc),
        .i_level          (i_left_level),
        .i_debounce_ticks (r_debounce_ticks),
        .o_fire           (left_fire)
    );

    hss_debounce u_right_db (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (in_acc),
        .i_level          (i_right_level),
        .i_debounce_ticks (r_debounce_ticks),
        .o_fire           (right_fire)
    );

    always_comb begin
        // left is handled before right, so right wins when both light up
        left_mid     = r_left_lamp ^ left_fire;
        right_mid    = (left_fire && left_mid) ? 1'b0 : r_right_lamp;
        n_right_lamp = right_mid ^ right_fire;
        n_left_lamp  = (right_fire && n_right_lamp) ? 1'b0 : left_mid;

        since_inc = (r_since == COUNT_MAX) ? r_since : r_since + 1'b1;
        step_now  = (n_left_lamp || n_right_lamp) && (since_inc >= r_step_period);

        n_since = since_inc;
        n_phase = r_phase;
        n_coils = r_coils;
        if (!n_left_lamp && !n_right_lamp) begin
            n_coils = COILS_OFF;
        end else if (step_now) begin
            n_coils = hss_phase_coils(r_phase);
            n_phase = n_left_lamp ? r_phase + 1'b1 : r_phase - 1'b1;
            n_since = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_lamp  <= 1'b0;
            r_right_lamp <= 1'b0;
            r_phase      <= '0;
            r_since      <= '0;
            r_coils      <= COILS_OFF;
        end else if (in_acc) begin
            r_left_lamp  <= n_left_lamp;
            r_right_lamp <= n_right_lamp;
            r_phase      <= n_phase;
            r_since      <= n_since;
            r_coils      <= n_coils;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_coils   <= n_coils;
            r_out_left    <= n_left_lamp;
            r_out_right   <= n_right_lamp;
            r_out_stepped <= step_now;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_coil_drive    = r_out_coils;
    assign o_left_lamp_on  = r_out_left;
    assign o_right_lamp_on = r_out_right;
    assign o_stepped       = r_out_stepped;

    a_lamps_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_left_lamp && r_right_lamp))
        else $error("both lamps lit");

    a_coils_off_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_left_lamp_on && !o_right_lamp_on) |-> (o_coil_drive == COILS_OFF))
        else $error("coils driven with no lamp lit");

    a_step_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && step_now) |=> (r_since == '0))
        else $error("step did not restart the period count");

    a_phase_moves_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && step_now) |=> $stable(r_phase))
        else $error("phase moved without a step");

    a_result_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted tick produced no result");

endmodule
